FILE: src/rgbmg_pkg.sv
// ----------------------------------------------------------------------------
// rgbmg_pkg
// Shared types and constants of the max-channel gradient magnitude block.
// ----------------------------------------------------------------------------
package rgbmg_pkg;

    localparam int CHAN_W         = 8;
    localparam int MAG_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam int FRAME_WIDTH_RST  = 1024;
    localparam int FRAME_HEIGHT_RST = 1024;
    localparam int MAG_MAX          = 255;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             frame_end;
    } result_t;

    // operand pairs of one magnitude: x pair, y pair, each optionally doubled
    typedef struct packed {
        pixel_t x_a;
        pixel_t x_b;
        logic   x_dbl;
        pixel_t y_a;
        pixel_t y_b;
        logic   y_dbl;
    } grad_op_t;

endpackage

FILE: src/rgbmg_ram.sv
// ----------------------------------------------------------------------------
// rgbmg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rgbmg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rgbmg_grad.sv
// ----------------------------------------------------------------------------
// rgbmg_grad
// One gradient magnitude: max-channel absolute differences for x and y,
// optional doubling, sum saturated to 8 bits.
// ----------------------------------------------------------------------------
module rgbmg_grad
    import rgbmg_pkg::*;
(
    input  grad_op_t         op,
    output logic [MAG_W-1:0] magnitude
);

    function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a,
                                                   logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [CHAN_W-1:0] max_diff(pixel_t a, pixel_t b);
        logic [CHAN_W-1:0] d_b;
        logic [CHAN_W-1:0] d_g;
        logic [CHAN_W-1:0] d_r;
        logic [CHAN_W-1:0] best;
        d_b  = abs_diff(a.blue, b.blue);
        d_g  = abs_diff(a.green, b.green);
        d_r  = abs_diff(a.red, b.red);
        best = (d_g > d_b) ? d_g : d_b;
        best = (d_r > best) ? d_r : best;
        return best;
    endfunction

    logic [CHAN_W-1:0] dx;
    logic [CHAN_W-1:0] dy;
    logic [CHAN_W:0]   gx;
    logic [CHAN_W:0]   gy;
    logic [CHAN_W+1:0] sum;

    always_comb
    begin
        dx  = max_diff(op.x_a, op.x_b);
        dy  = max_diff(op.y_a, op.y_b);
        gx  = op.x_dbl ? {dx, 1'b0} : {1'b0, dx};
        gy  = op.y_dbl ? {dy, 1'b0} : {1'b0, dy};
        sum = (CHAN_W+2)'(gx) + (CHAN_W+2)'(gy);
        if (sum > (CHAN_W+2)'(MAG_MAX))
        begin
            magnitude = MAG_W'(MAG_MAX);
        end
        else
        begin
            magnitude = sum[MAG_W-1:0];
        end
    end

endmodule

FILE: src/rgb_max_gradient_magnitude_core.sv
// ----------------------------------------------------------------------------
// rgb_max_gradient_magnitude_core
// Streaming max-channel gradient magnitude over BGR pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while the result queue has room
// and returns, for every pixel, min(Ix + Iy, 255), where Ix and Iy are the
// largest per-channel absolute differences of the horizontal and vertical
// neighbours (doubled one-sided differences on the frame border). Magnitudes
// trail the input by one row; row 0 produces nothing, and during the last
// row each pixel also releases the last row's magnitudes, so the final pixel
// carries frame_end. Results are registered, then queued. The two row stores
// are single-port-read RAMs read one column ahead, so a pixel can be taken
// every cycle; results leave a 4-entry queue one per cycle while
// result_ready is high, which in the last row (up to three results per
// pixel) holds the input back. Writing either register restarts the frame
// at pixel (0, 0). No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rgb_max_gradient_magnitude_core
    import rgbmg_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  pixel_t                 pixel,

    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WCMP = (FRAME_WIDTH_W > $clog2(MAX_WIDTH + 1)) ?
                          FRAME_WIDTH_W : $clog2(MAX_WIDTH + 1);
    localparam int HCMP = (FRAME_HEIGHT_W > $clog2(MAX_HEIGHT + 1)) ?
                          FRAME_HEIGHT_W : $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;
    localparam int PW = 3 * CHAN_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        pixel_t cur;
        pixel_t mid;
        pixel_t rgt;
        pixel_t lft;
        pixel_t old;
        pixel_t prv;
        pixel_t prv2;
        logic   c0;
        logic   c1;
        logic   clast;
        logic   r0;
        logic   r1;
        logic   rlast;
    } stage_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag2;
        logic [MAG_W-1:0] mag1;
        logic [MAG_W-1:0] mag0;
        logic             fe;
        logic [1:0]       cnt;
    } bundle_t;

    // ---------------- control and geometry ----------------
    logic [AW-1:0] wlast_reg, wlast_next;
    logic [RW-1:0] hlast_reg, hlast_next;
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    pixel_t        prev_reg, prev_next;
    pixel_t        prev2_reg, prev2_next;
    pixel_t        head_reg, head_next;      // column 0 pixel of the previous row
    pixel_t        rprev_reg, rprev_next;    // previous row, current column
    pixel_t        left_reg, left_next;      // previous row, column to the left
    logic          byp_v_reg, byp_v_next;
    pixel_t        byp_d_reg, byp_d_next;

    logic          accept;
    logic [AW-1:0] next_col;
    logic [AW-1:0] newer_raddr;
    logic [PW-1:0] newer_rdata;
    logic [PW-1:0] older_rdata;
    pixel_t        right_px;
    pixel_t        mid_px;
    logic [WCMP-1:0] wval;
    logic [HCMP-1:0] hval;

    stage_t        st_reg, st_next;
    logic          st_v_reg, st_v_next;

    assign accept   = pixel_valid && pixel_ready;
    assign next_col = (col_reg == wlast_reg) ? '0 : col_reg + AW'(1);
    assign newer_raddr = (next_col == wlast_reg) ? '0 : next_col + AW'(1);
    assign right_px = byp_v_reg ? byp_d_reg : pixel_t'(newer_rdata);
    assign mid_px   = (col_reg == '0) ? head_reg : rprev_reg;

    // newer store: the last row seen, read one column ahead
    rgbmg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (PW'(pixel)),
        .re    (accept),
        .raddr (newer_raddr),
        .rdata (newer_rdata)
    );

    // older store: the row before that, read at the next column
    rgbmg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (PW'(mid_px)),
        .re    (accept),
        .raddr (next_col),
        .rdata (older_rdata)
    );

    always_comb
    begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        prev_next  = prev_reg;
        prev2_next = prev2_reg;
        head_next  = head_reg;
        rprev_next = rprev_reg;
        left_next  = left_reg;
        byp_v_next = byp_v_reg;
        byp_d_next = byp_d_reg;
        st_next    = st_reg;
        st_v_next  = accept;
        wval       = WCMP'(cfg_data[FRAME_WIDTH_W-1:0]);
        hval       = HCMP'(cfg_data[FRAME_HEIGHT_W-1:0]);

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (wval < WCMP'(2))
                        wlast_next = AW'(1);
                    else if (wval > WCMP'(MAX_WIDTH))
                        wlast_next = AW'(MAX_WIDTH - 1);
                    else
                        wlast_next = AW'(wval - WCMP'(1));
                end
                REG_FRAME_HEIGHT:
                begin
                    if (hval < HCMP'(2))
                        hlast_next = RW'(1);
                    else if (hval > HCMP'(MAX_HEIGHT))
                        hlast_next = RW'(MAX_HEIGHT - 1);
                    else
                        hlast_next = RW'(hval - HCMP'(1));
                end
                default:
                begin
                    wlast_next = wlast_reg;
                end
            endcase
            col_next   = '0;
            row_next   = '0;
            prev_next  = '0;
            prev2_next = '0;
        end
        else if (accept)
        begin
            st_next.cur   = pixel;
            st_next.mid   = mid_px;
            st_next.rgt   = right_px;
            st_next.lft   = left_reg;
            st_next.old   = pixel_t'(older_rdata);
            st_next.prv   = prev_reg;
            st_next.prv2  = prev2_reg;
            st_next.c0    = (col_reg == '0);
            st_next.c1    = (col_reg == AW'(1));
            st_next.clast = (col_reg == wlast_reg);
            st_next.r0    = (row_reg == '0);
            st_next.r1    = (row_reg == RW'(1));
            st_next.rlast = (row_reg == hlast_reg);

            prev2_next = prev_reg;
            prev_next  = pixel;
            rprev_next = right_px;
            left_next  = mid_px;
            if (col_reg == '0)
                head_next = pixel;
            // read and write of the same entry in one cycle (narrow frames)
            byp_v_next = (newer_raddr == col_reg);
            byp_d_next = pixel;

            col_next = next_col;
            if (col_reg == wlast_reg)
            begin
                row_next = (row_reg == hlast_reg) ? '0 : row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= AW'(W_RST - 1);
            hlast_reg <= RW'(H_RST - 1);
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
            prev2_reg <= '0;
            byp_v_reg <= 1'b0;
            st_v_reg  <= 1'b0;
        end
        else
        begin
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            prev_reg  <= prev_next;
            prev2_reg <= prev2_next;
            byp_v_reg <= byp_v_next;
            st_v_reg  <= st_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        rprev_reg <= rprev_next;
        left_reg  <= left_next;
        byp_d_reg <= byp_d_next;
        st_reg    <= st_next;
    end

    // ---------------- magnitude stage ----------------
    grad_op_t         op0, op1, op2;
    logic [MAG_W-1:0] mag0, mag1, mag2;
    bundle_t          bnd;

    always_comb
    begin
        // previous row, same column
        op0.x_a   = st_reg.c0 ? st_reg.rgt : (st_reg.clast ? st_reg.mid : st_reg.lft);
        op0.x_b   = st_reg.c0 ? st_reg.mid : (st_reg.clast ? st_reg.lft : st_reg.rgt);
        op0.x_dbl = st_reg.c0 || st_reg.clast;
        op0.y_a   = st_reg.r1 ? st_reg.cur : st_reg.old;
        op0.y_b   = st_reg.r1 ? st_reg.mid : st_reg.cur;
        op0.y_dbl = st_reg.r1;
        // last row, column to the left
        op1.x_a   = st_reg.c1 ? st_reg.cur : st_reg.prv2;
        op1.x_b   = st_reg.c1 ? st_reg.prv : st_reg.cur;
        op1.x_dbl = st_reg.c1;
        op1.y_a   = st_reg.prv;
        op1.y_b   = st_reg.lft;
        op1.y_dbl = 1'b1;
        // last row, last column
        op2.x_a   = st_reg.cur;
        op2.x_b   = st_reg.prv;
        op2.x_dbl = 1'b1;
        op2.y_a   = st_reg.cur;
        op2.y_b   = st_reg.mid;
        op2.y_dbl = 1'b1;
    end

    rgbmg_grad u_grad0 (.op(op0), .magnitude(mag0));
    rgbmg_grad u_grad1 (.op(op1), .magnitude(mag1));
    rgbmg_grad u_grad2 (.op(op2), .magnitude(mag2));

    always_comb
    begin
        bnd.mag0 = mag0;
        bnd.mag1 = mag1;
        bnd.mag2 = mag2;
        bnd.fe   = st_reg.rlast && st_reg.clast;
        if (st_reg.r0)
            bnd.cnt = 2'd0;
        else if (!st_reg.rlast || st_reg.c0)
            bnd.cnt = 2'd1;
        else if (st_reg.clast)
            bnd.cnt = 2'd3;
        else
            bnd.cnt = 2'd2;
    end

    // ---------------- result queue ----------------
    bundle_t           fifo_reg [FIFO_DEPTH];
    logic [FP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FC_W-1:0]   fcnt_reg, fcnt_next;
    logic [1:0]        sub_reg, sub_next;
    bundle_t           head_bnd;
    logic              push;
    logic              pop;
    logic              out_take;

    assign head_bnd = fifo_reg[rd_ptr_reg];
    assign push     = st_v_reg && (bnd.cnt != 2'd0);
    assign out_take = result_valid && result_ready;
    assign pop      = out_take && (sub_reg == head_bnd.cnt - 2'd1);

    // room for the item in the magnitude stage and one more
    assign pixel_ready  = (fcnt_reg + FC_W'(st_v_reg)) < FC_W'(FIFO_DEPTH);
    assign result_valid = (fcnt_reg != '0);

    always_comb
    begin
        case (sub_reg)
            2'd0:    result.magnitude = head_bnd.mag0;
            2'd1:    result.magnitude = head_bnd.mag1;
            default: result.magnitude = head_bnd.mag2;
        endcase
        result.frame_end = head_bnd.fe && (sub_reg == 2'd2);
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FP_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FP_W'(1) : rd_ptr_reg;
        fcnt_next   = fcnt_reg + FC_W'(push) - FC_W'(pop);
        if (pop)
            sub_next = 2'd0;
        else if (out_take)
            sub_next = sub_reg + 2'd1;
        else
            sub_next = sub_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fcnt_reg   <= fcnt_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= bnd;
        end
    end

endmodule

FILE: src/rgbmg_checker.sv
// ----------------------------------------------------------------------------
// rgbmg_checker
// Port-level checks of the gradient magnitude core, bound to the top level.
// ----------------------------------------------------------------------------
module rgbmg_checker
    import rgbmg_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pixel_valid,
    input logic                   pixel_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input result_t                result
);

    // a stalled result transaction keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // results only appear from an empty queue after a pixel passes the magnitude stage
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid && pixel_ready, 2))
        else $error("result without a preceding pixel transaction");

    // a frame holds at least four pixels, so frame ends never follow each other
    a_frame_end_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.frame_end
            |=> !(result_valid && result.frame_end))
        else $error("back-to-back frame_end");

endmodule

bind rgb_max_gradient_magnitude_core rgbmg_checker u_rgbmg_checker (.*);
